// ----- rtl/window_sender_congestion_control_top_defines.svh -----
// assertion macros for the window sender block
// used by window_sender_congestion_control_top, no other dependencies
`ifndef WINDOW_SENDER_CONGESTION_CONTROL_TOP_DEFINES_SVH
`define WINDOW_SENDER_CONGESTION_CONTROL_TOP_DEFINES_SVH

// same-cycle implication under synchronous active-low reset
`define WSCC_ASSERT_NOW(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("window sender assertion failed");

// next-cycle implication under synchronous active-low reset
`define WSCC_ASSERT_NEXT(label, clk, rst_n, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("window sender assertion failed");

`endif

// ----- rtl/wscc_pkg.sv -----
// types, constants and codes of the window sender block
// no dependencies
package wscc_pkg;

  localparam int SLOTS      = 512;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int MAX_WINDOW = 32;
  localparam int WIN_W      = 6;
  localparam int TIME_W     = 48;
  localparam int SEQ_W      = 16;
  localparam int SLOT_W     = 9;
  localparam int LS_W       = ((CNT_W > WIN_W) ? CNT_W : WIN_W) + 1;
  localparam int NUM_W      = 52;
  localparam int NUM_NIBS   = NUM_W / 4;
  localparam int ADDR_W     = 5;

  typedef enum logic [1:0] {
    OP_INIT    = 2'd0,
    OP_ENQUEUE = 2'd1,
    OP_ACK     = 2'd2,
    OP_TICK    = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_TRANSMIT = 2'd0,
    KIND_CLOSED   = 2'd1,
    KIND_STATUS   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    REG_INIT_WIN   = 3'd0,
    REG_INIT_SS    = 3'd1,
    REG_DUP_THR    = 3'd2,
    REG_RTT_WEIGHT = 3'd3,
    REG_TIMEOUT    = 3'd4,
    REG_RESEND_LIM = 3'd5,
    REG_PAUSED     = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [TIME_W-1:0] now_us;
    logic [SEQ_W-1:0]  packet_seq;
    logic [SEQ_W-1:0]  ack_number;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [SLOT_W-1:0] slot;
    logic [WIN_W-1:0]  window;
    logic              avoidance;
    logic              error;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [TIME_W-1:0] send_time;
    logic              sent;
    logic [3:0]        resends;
  } slot_entry_t;

endpackage

// ----- rtl/window_sender_congestion_control_top.sv -----
// window sender with slow start and congestion avoidance, slot table in one RAM
// depends on wscc_pkg and window_sender_congestion_control_top_defines.svh
`include "window_sender_congestion_control_top_defines.svh"

// Usage
// Items enter on in_item when start is high and busy is low. Each item yields
// zero or more transmit or closed results and always ends with one status
// result (last = 1). Every result is on out_item for one cycle with out_strobe.
// The user must write registers over the APB port only while the block is idle;
// the block itself does not enforce this. An init goes straight to the status
// result, an enqueue stores its packet first, and a tick walks the slots unless gated off.
// An ack runs the duplicate scan, retires slots from head, takes an RTT update
// (divide by ten) for a retired sent slot when the update is taken, then sends
// newly allowed slots. Every slot access goes through a registered read of the
// slot RAM, which has separate read and write ports.
// The slot table tracks fill by tail index, so no clearing pass is needed:
// reset and init take effect at once. Results cannot be held off by the
// receiver; busy stays high until the status result has been issued.
module window_sender_congestion_control_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  wscc_pkg::in_item_t        in_item,
  output logic                      out_strobe,
  output wscc_pkg::out_item_t       out_item,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [wscc_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import wscc_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE     = 17'h00001,
    S_ENQ      = 17'h00002,
    S_ACK      = 17'h00004,
    S_SCAN_RD  = 17'h00008,
    S_SCAN_CHK = 17'h00010,
    S_FR_RD    = 17'h00020,
    S_FR_WR    = 17'h00040,
    S_RET_RD   = 17'h00080,
    S_RET_CHK  = 17'h00100,
    S_MUL      = 17'h00200,
    S_DIV      = 17'h00400,
    S_POST     = 17'h00800,
    S_SEND_RD  = 17'h01000,
    S_SEND_WR  = 17'h02000,
    S_TICK_RD  = 17'h04000,
    S_TICK_CHK = 17'h08000,
    S_STATUS   = 17'h10000
  } state_t;

  // helpers
  function automatic logic [TIME_W-1:0] elapsed(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
    return (a >= b) ? (a - b) : '0;
  endfunction

  function automatic logic [3:0] div10(input logic [7:0] x);
    logic [3:0] q;
    q = '0;
    for (int k = 1; k < 16; k++) begin
      if (x >= 8'(k * 10)) q = 4'(k);
    end
    return q;
  endfunction

  // configuration registers
  logic [WIN_W-1:0] cfg_init_win_r, cfg_init_ss_r;
  logic [3:0]       cfg_dup_thr_r, cfg_rtt_w_r, cfg_resend_lim_r;
  logic [31:0]      cfg_timeout_r;
  logic             cfg_paused_r;
  logic [2:0]       cfg_idx;
  logic             cfg_wr;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_init_win_r   <= WIN_W'(1);
      cfg_init_ss_r    <= WIN_W'(16);
      cfg_dup_thr_r    <= 4'd3;
      cfg_rtt_w_r      <= 4'd8;
      cfg_timeout_r    <= 32'd1000000;
      cfg_resend_lim_r <= 4'd5;
      cfg_paused_r     <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_INIT_WIN:   cfg_init_win_r   <= pwdata[WIN_W-1:0];
        REG_INIT_SS:    cfg_init_ss_r    <= pwdata[WIN_W-1:0];
        REG_DUP_THR:    cfg_dup_thr_r    <= pwdata[3:0];
        REG_RTT_WEIGHT: cfg_rtt_w_r      <= pwdata[3:0];
        REG_TIMEOUT:    cfg_timeout_r    <= pwdata;
        REG_RESEND_LIM: cfg_resend_lim_r <= pwdata[3:0];
        REG_PAUSED:     cfg_paused_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    prdata = '0;
    case (cfg_idx)
      REG_INIT_WIN:   prdata = 32'(cfg_init_win_r);
      REG_INIT_SS:    prdata = 32'(cfg_init_ss_r);
      REG_DUP_THR:    prdata = 32'(cfg_dup_thr_r);
      REG_RTT_WEIGHT: prdata = 32'(cfg_rtt_w_r);
      REG_TIMEOUT:    prdata = cfg_timeout_r;
      REG_RESEND_LIM: prdata = 32'(cfg_resend_lim_r);
      REG_PAUSED:     prdata = 32'(cfg_paused_r);
      default:        prdata = '0;
    endcase
  end

  // slot table memory
  slot_entry_t      mem [SLOTS];
  slot_entry_t      rd_q, mem_wd;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] mem_wa, mem_ra;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_q <= mem[mem_ra];
  end

  // sender state
  state_t           state_r, state_nxt;
  in_item_t         item_r;
  logic [WIN_W-1:0] win_r, win_nxt, ss_r, ss_nxt;
  logic             av_r, av_nxt, err_r, err_nxt;
  logic [CNT_W-1:0] head_r, head_nxt, tail_r, tail_nxt, idx_r, idx_nxt;
  logic [LS_W-1:0]  last_sent_r, last_sent_nxt;
  logic [SEQ_W-1:0] last_ack_r, last_ack_nxt;
  logic [3:0]       dup_r, dup_nxt, dcnt_r, dcnt_nxt, drem_r, drem_nxt;
  logic [TIME_W-1:0] rtt_r, rtt_nxt, wut_r, wut_nxt, ltt_r, ltt_nxt;
  logic [TIME_W-1:0] sample_r, sample_nxt;
  logic [NUM_W-1:0]  acc_r, acc_nxt;
  logic              out_strobe_r, out_strobe_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              accept;
  logic [TIME_W-1:0] now, e_slot;
  logic [SEQ_W-1:0]  ack;
  logic [3:0]        dup_inc, res_inc, w_eff;
  logic [WIN_W-1:0]  half;
  logic [WIN_W-1:0]  loss_ss;
  logic [54:0]       e50;
  logic [7:0]        dx, dr;
  logic [3:0]        dq;
  logic [CNT_W-1:0]  tail_diff, idx_diff;
  logic [SEQ_W-1:0]  la_diff;
  logic              la_valid;

  assign busy       = (state_r != S_IDLE);
  assign accept     = start & ~busy;
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;
  assign now        = item_r.now_us;
  assign ack        = item_r.ack_number;

  // shared datapath terms
  always_comb begin
    dup_inc   = (dup_r == 4'd15) ? dup_r : dup_r + 4'd1;
    res_inc   = (rd_q.resends == 4'd15) ? rd_q.resends : rd_q.resends + 4'd1;
    w_eff     = (cfg_rtt_w_r > 4'd10) ? 4'd10 : cfg_rtt_w_r;
    half      = win_r >> 1;
    loss_ss   = (half > WIN_W'(2)) ? half : WIN_W'(2);
    e_slot    = elapsed(now, rd_q.send_time);
    e50       = {2'b0, e_slot, 5'b0} + {3'b0, e_slot, 4'b0} + {6'b0, e_slot, 1'b0}
                + 55'd50;
    dx        = {drem_r, acc_r[NUM_W-1 -: 4]};
    dq        = div10(dx);
    dr        = dx - ((8'(dq) << 3) + (8'(dq) << 1));
    tail_diff = tail_r - head_r;
    idx_diff  = idx_r - head_r;
    la_diff   = last_ack_r - SEQ_W'(head_r);
    la_valid  = (32'(last_ack_r) < SLOTS) && (last_ack_r >= SEQ_W'(head_r)) &&
                (last_ack_r < SEQ_W'(tail_r));
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    win_nxt        = win_r;
    ss_nxt         = ss_r;
    av_nxt         = av_r;
    err_nxt        = err_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    idx_nxt        = idx_r;
    last_sent_nxt  = last_sent_r;
    last_ack_nxt   = last_ack_r;
    dup_nxt        = dup_r;
    rtt_nxt        = rtt_r;
    wut_nxt        = wut_r;
    ltt_nxt        = ltt_r;
    sample_nxt     = sample_r;
    acc_nxt        = acc_r;
    dcnt_nxt       = dcnt_r;
    drem_nxt       = drem_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = '0;
    mem_we         = 1'b0;
    mem_wa         = idx_r[IDX_W-1:0];
    mem_wd         = rd_q;
    mem_re         = 1'b0;
    mem_ra         = idx_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          err_nxt = 1'b0;
          case (in_item.opcode)
            OP_INIT: begin
              win_nxt      = (cfg_init_win_r > WIN_W'(MAX_WINDOW)) ?
                             WIN_W'(MAX_WINDOW) : cfg_init_win_r;
              ss_nxt       = cfg_init_ss_r;
              av_nxt       = 1'b0;
              head_nxt     = '0;
              tail_nxt     = '0;
              last_ack_nxt = '0;
              dup_nxt      = '0;
              rtt_nxt      = '0;
              wut_nxt      = in_item.now_us;
              ltt_nxt      = '0;
              state_nxt    = S_STATUS;
            end
            OP_ENQUEUE: state_nxt = S_ENQ;
            OP_ACK:     state_nxt = S_ACK;
            default:    state_nxt = S_TICK_RD;
          endcase
          idx_nxt = head_r;
          // tick gate is checked here on the live request
          if (in_item.opcode == OP_TICK) begin
            if (cfg_paused_r ||
                ({1'b0, elapsed(in_item.now_us, ltt_r)} < {rtt_r, 1'b0})) begin
              state_nxt = S_STATUS;
            end else begin
              ltt_nxt = in_item.now_us;
            end
          end
        end
      end

      // store a new packet if the table has room, send it if the window has room
      S_ENQ: begin
        if (32'(tail_r) >= SLOTS) begin
          err_nxt = 1'b1;
        end else begin
          mem_we           = 1'b1;
          mem_wa           = tail_r[IDX_W-1:0];
          mem_wd.seq       = item_r.packet_seq;
          mem_wd.send_time = now;
          mem_wd.sent      = (tail_diff < CNT_W'(win_r));
          mem_wd.resends   = '0;
          if (tail_diff < CNT_W'(win_r)) begin
            out_strobe_nxt    = 1'b1;
            out_item_nxt.kind = KIND_TRANSMIT;
            out_item_nxt.slot = SLOT_W'(tail_r);
          end
          tail_nxt = tail_r + CNT_W'(1);
        end
        state_nxt = S_STATUS;
      end

      // duplicate ack handling and window growth
      S_ACK: begin
        last_sent_nxt = LS_W'(head_r) + LS_W'(win_r);
        idx_nxt       = head_r;
        state_nxt     = S_RET_RD;
        if (ack == last_ack_r) begin
          dup_nxt = dup_inc;
          if (dup_inc >= cfg_dup_thr_r) state_nxt = S_SCAN_RD;
        end else if (ack > last_ack_r) begin
          last_ack_nxt = ack;
          dup_nxt      = 4'd1;
          if (!av_r) begin
            win_nxt = (win_r < WIN_W'(MAX_WINDOW)) ? win_r + WIN_W'(1) : win_r;
            if (win_nxt > ss_r) av_nxt = 1'b1;
            wut_nxt = now;
          end else if (elapsed(now, wut_r) >= rtt_r) begin
            win_nxt = (win_r < WIN_W'(MAX_WINDOW)) ? win_r + WIN_W'(1) : win_r;
            wut_nxt = now;
          end
        end
      end

      // look for a recent send of the acked sequence number
      S_SCAN_RD: begin
        if (idx_r < tail_r) begin
          mem_re    = 1'b1;
          state_nxt = S_SCAN_CHK;
        end else begin
          idx_nxt   = head_r;
          state_nxt = S_RET_RD;
          if (32'(last_ack_r) < SLOTS) begin
            ss_nxt  = loss_ss;
            win_nxt = WIN_W'(1);
            av_nxt  = 1'b0;
            if (la_valid) state_nxt = S_FR_RD;
          end
        end
      end

      S_SCAN_CHK: begin
        if (rd_q.sent && (rd_q.seq == ack) &&
            (e50 <= {7'b0, rtt_r})) begin
          dup_nxt   = dup_r - 4'd1;
          idx_nxt   = head_r;
          state_nxt = S_RET_RD;
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_SCAN_RD;
        end
      end

      // fast retransmit of the slot at last ack
      S_FR_RD: begin
        mem_re    = 1'b1;
        mem_ra    = last_ack_r[IDX_W-1:0];
        state_nxt = S_FR_WR;
      end

      S_FR_WR: begin
        mem_we      = 1'b1;
        mem_wa      = last_ack_r[IDX_W-1:0];
        mem_wd.sent = (la_diff <= SEQ_W'(1));
        if (la_diff <= SEQ_W'(1)) begin
          mem_wd.send_time  = now;
          out_strobe_nxt    = 1'b1;
          out_item_nxt.kind = KIND_TRANSMIT;
          out_item_nxt.slot = SLOT_W'(last_ack_r);
        end
        idx_nxt   = head_r;
        state_nxt = S_RET_RD;
      end

      // retire acked slots from head
      S_RET_RD: begin
        if (idx_r < tail_r) begin
          mem_re    = 1'b1;
          state_nxt = S_RET_CHK;
        end else begin
          head_nxt  = idx_r;
          state_nxt = S_POST;
        end
      end

      S_RET_CHK: begin
        if (rd_q.seq >= ack) begin
          head_nxt  = idx_r;
          state_nxt = S_POST;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
          if (rd_q.sent) begin
            sample_nxt = e_slot;
            state_nxt  = S_MUL;
          end else begin
            state_nxt = S_RET_RD;
          end
        end
      end

      // weighted sum for the rtt estimate
      S_MUL: begin
        if (({sample_r, 5'b0} + {1'b0, sample_r, 4'b0} + {4'b0, sample_r, 1'b0}) <
            {6'b0, rtt_r}) begin
          state_nxt = S_RET_RD;
        end else begin
          acc_nxt   = NUM_W'(w_eff) * NUM_W'(rtt_r) +
                      NUM_W'(4'd10 - w_eff) * NUM_W'(sample_r);
          drem_nxt  = '0;
          dcnt_nxt  = 4'(NUM_NIBS - 1);
          state_nxt = S_DIV;
        end
      end

      // divide by ten, one nibble per cycle
      S_DIV: begin
        acc_nxt  = {acc_r[NUM_W-5:0], dq};
        drem_nxt = dr[3:0];
        dcnt_nxt = dcnt_r - 4'd1;
        if (dcnt_r == 4'd0) begin
          rtt_nxt   = acc_nxt[TIME_W-1:0];
          state_nxt = S_RET_RD;
        end
      end

      // closed on final ack, else start sending newly allowed slots
      S_POST: begin
        if (32'(ack) >= SLOTS) begin
          out_strobe_nxt    = 1'b1;
          out_item_nxt.kind = KIND_CLOSED;
          state_nxt         = S_STATUS;
        end else if (last_sent_r >= LS_W'(tail_r)) begin
          state_nxt = S_STATUS;
        end else begin
          idx_nxt   = (last_sent_r > LS_W'(head_r)) ? CNT_W'(last_sent_r) : head_r;
          state_nxt = S_SEND_RD;
        end
      end

      S_SEND_RD: begin
        if ((idx_r < tail_r) && (idx_diff < CNT_W'(win_r))) begin
          mem_re    = 1'b1;
          state_nxt = S_SEND_WR;
        end else begin
          state_nxt = S_STATUS;
        end
      end

      S_SEND_WR: begin
        mem_we            = 1'b1;
        mem_wd.sent       = 1'b1;
        mem_wd.send_time  = now;
        out_strobe_nxt    = 1'b1;
        out_item_nxt.kind = KIND_TRANSMIT;
        out_item_nxt.slot = SLOT_W'(idx_r);
        idx_nxt           = idx_r + CNT_W'(1);
        state_nxt         = S_SEND_RD;
      end

      // timeout walk over sent slots
      S_TICK_RD: begin
        if (idx_r < tail_r) begin
          mem_re    = 1'b1;
          state_nxt = S_TICK_CHK;
        end else begin
          state_nxt = S_STATUS;
        end
      end

      S_TICK_CHK: begin
        if (!rd_q.sent) begin
          state_nxt = S_STATUS;
        end else if (e_slot > {16'b0, cfg_timeout_r}) begin
          mem_we         = 1'b1;
          mem_wd.resends = res_inc;
          state_nxt      = S_STATUS;
          if (res_inc > cfg_resend_lim_r) begin
            out_strobe_nxt    = 1'b1;
            out_item_nxt.kind = KIND_CLOSED;
          end else begin
            ss_nxt      = loss_ss;
            win_nxt     = WIN_W'(1);
            av_nxt      = 1'b0;
            mem_wd.sent = (idx_diff <= CNT_W'(1));
            if (idx_diff <= CNT_W'(1)) begin
              mem_wd.send_time  = now;
              out_strobe_nxt    = 1'b1;
              out_item_nxt.kind = KIND_TRANSMIT;
              out_item_nxt.slot = SLOT_W'(idx_r);
            end
          end
        end else begin
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = S_TICK_RD;
        end
      end

      // final status of the request
      S_STATUS: begin
        out_strobe_nxt         = 1'b1;
        out_item_nxt.kind      = KIND_STATUS;
        out_item_nxt.window    = win_r;
        out_item_nxt.avoidance = av_r;
        out_item_nxt.error     = err_r;
        out_item_nxt.last      = 1'b1;
        state_nxt              = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      win_r        <= WIN_W'(1);
      ss_r         <= WIN_W'(16);
      av_r         <= 1'b0;
      err_r        <= 1'b0;
      head_r       <= '0;
      tail_r       <= '0;
      last_ack_r   <= '0;
      dup_r        <= '0;
      rtt_r        <= '0;
      wut_r        <= '0;
      ltt_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      win_r        <= win_nxt;
      ss_r         <= ss_nxt;
      av_r         <= av_nxt;
      err_r        <= err_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      last_ack_r   <= last_ack_nxt;
      dup_r        <= dup_nxt;
      rtt_r        <= rtt_nxt;
      wut_r        <= wut_nxt;
      ltt_r        <= ltt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) item_r <= in_item;
    idx_r       <= idx_nxt;
    last_sent_r <= last_sent_nxt;
    sample_r    <= sample_nxt;
    acc_r       <= acc_nxt;
    dcnt_r      <= dcnt_nxt;
    drem_r      <= drem_nxt;
    out_item_r  <= out_item_nxt;
  end

  // checks
  `WSCC_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy)
  `WSCC_ASSERT_NOW(a_head_le_tail, clk, rst_n, 1'b1, head_r <= tail_r)
  `WSCC_ASSERT_NOW(a_win_max, clk, rst_n, 1'b1, win_r <= WIN_W'(MAX_WINDOW))
  `WSCC_ASSERT_NEXT(a_status_last, clk, rst_n, state_r == S_STATUS,
                    out_strobe && out_item.last)

endmodule
